// ===== hw/rtl/opm_pkg.sv =====
// ----------------------------------------------------------------------------
// opm_pkg
// Shared opcodes, widths and helpers of the opmask register unit.
// ----------------------------------------------------------------------------
package opm_pkg;

   localparam int DATA_W  = 64;
   localparam int OP_W    = 4;
   localparam int WSEL_W  = 2;
   localparam int RIDX_W  = 3;
   localparam int CNT_W   = 8;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [OP_W-1:0]   op_type;

   localparam op_type OP_MOV    = 4'd0;
   localparam op_type OP_ADD    = 4'd1;
   localparam op_type OP_AND    = 4'd2;
   localparam op_type OP_ANDN   = 4'd3;
   localparam op_type OP_OR     = 4'd4;
   localparam op_type OP_XOR    = 4'd5;
   localparam op_type OP_XNOR   = 4'd6;
   localparam op_type OP_NOT    = 4'd7;
   localparam op_type OP_SHL    = 4'd8;
   localparam op_type OP_SHR    = 4'd9;
   localparam op_type OP_UNPACK = 4'd10;
   localparam op_type OP_ORTEST = 4'd11;
   localparam op_type OP_TEST   = 4'd12;

   localparam logic [WSEL_W-1:0] W_8  = 2'd0;
   localparam logic [WSEL_W-1:0] W_16 = 2'd1;
   localparam logic [WSEL_W-1:0] W_32 = 2'd2;
   localparam logic [WSEL_W-1:0] W_64 = 2'd3;

   function automatic data_type width_mask(input logic [WSEL_W-1:0] sel);
      data_type m;
      case (sel)
         W_8:     m = 64'h0000_0000_0000_00ff;
         W_16:    m = 64'h0000_0000_0000_ffff;
         W_32:    m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] width_bits(input logic [WSEL_W-1:0] sel);
      return CNT_W'(8) << sel;
   endfunction

endpackage

// ===== hw/rtl/opmask_register_unit.sv =====
// ----------------------------------------------------------------------------
// opmask_register_unit
// Executes one opmask instruction per item against a file of 64-bit mask
// registers held in a synchronous two-read, one-write memory.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  req     | req_valid, req_stall, req_*   | item in: opcode, indexes, operands
//  rsp     | rsp_valid, rsp_stall, rsp_*   | item out: result, write and flags
//
//  Each item first reads the register file, then executes and writes back;
//  the next item is taken once the write has landed.
//  Reset clears per-register valid bits; an invalid register reads as zero.
//  The result register frees the execute stage, so a stalled rsp holds at
//  most one item in execute and one at the output.
// ----------------------------------------------------------------------------
module opmask_register_unit
   import opm_pkg::*;
#(
   parameter int NUM_MASK_REGS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_type,
   input  logic [WSEL_W-1:0]   req_width_sel,
   input  logic [RIDX_W-1:0]   req_dest_index,
   input  logic [RIDX_W-1:0]   req_src1_index,
   input  logic [RIDX_W-1:0]   req_src2_index,
   input  logic                req_src_is_external,
   input  logic                req_dest_is_external,
   input  logic [DATA_W-1:0]   req_external_value,
   input  logic [CNT_W-1:0]    req_shift_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_result_value,
   output logic                rsp_reg_written,
   output logic                rsp_flags_valid,
   output logic                rsp_zero_flag,
   output logic                rsp_carry_flag
);

   localparam int IDX_W = (NUM_MASK_REGS > 1) ? $clog2(NUM_MASK_REGS) : 1;

   data_type                 mem [NUM_MASK_REGS];
   logic [NUM_MASK_REGS-1:0] vld_ff, vld_in;

   logic                stg_vld_ff, stg_vld_in;
   op_type              op_ff;
   logic [WSEL_W-1:0]   wsel_ff;
   logic [IDX_W-1:0]    dst_ff;
   logic                dst_ok_ff;
   logic                dst_ext_ff;
   logic                src_ext_ff;
   data_type            ext_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                s1_ok_ff, s2_ok_ff;
   data_type            rd1_ff, rd2_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   data_type            res_ff;
   logic                wr_ff, fv_ff, zf_ff, cf_ff;

   logic                req_acc, out_load, wr_en;
   logic [IDX_W-1:0]    a1, a2;
   logic                s1_in_range, s2_in_range, d_in_range;
   data_type            m, s1, s2, a, b, hm, res;
   logic [CNT_W-1:0]    bits;
   logic                store, fv, zf, cf, too_big;

   assign req_acc     = req_valid && !req_stall;
   assign req_stall   = stg_vld_ff;
   assign out_load    = stg_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign a1          = IDX_W'(req_src1_index);
   assign a2          = IDX_W'(req_src2_index);
   assign s1_in_range = 32'(req_src1_index) < NUM_MASK_REGS;
   assign s2_in_range = 32'(req_src2_index) < NUM_MASK_REGS;
   assign d_in_range  = 32'(req_dest_index) < NUM_MASK_REGS;

   // execute
   always_comb begin
      m       = width_mask(wsel_ff);
      bits    = width_bits(wsel_ff);
      s1      = s1_ok_ff ? rd1_ff : '0;
      s2      = src_ext_ff ? ext_ff : (s2_ok_ff ? rd2_ff : '0);
      a       = s1 & m;
      b       = s2 & m;
      too_big = cnt_ff >= bits;
      hm      = m >> (bits >> 1);
      res     = '0;
      store   = 1'b1;
      fv      = 1'b0;
      zf      = 1'b0;
      cf      = 1'b0;
      case (op_ff)
         OP_MOV:  res = b;
         OP_ADD:  res = a + b;
         OP_AND:  res = a & b;
         OP_ANDN: res = ~a & b;
         OP_OR:   res = a | b;
         OP_XOR:  res = a ^ b;
         OP_XNOR: res = ~(a ^ b);
         OP_NOT:  res = ~b;
         OP_SHL:  res = too_big ? '0 : (b << cnt_ff[5:0]);
         OP_SHR:  res = too_big ? '0 : (b >> cnt_ff[5:0]);
         OP_UNPACK: begin
            if (wsel_ff == W_8) begin
               store = 1'b0;
            end else begin
               res = ((s1 & hm) << (bits >> 1)) | (s2 & hm);
            end
         end
         OP_ORTEST: begin
            store = 1'b0;
            fv    = 1'b1;
            zf    = (a | b) == '0;
            cf    = (a | b) == m;
         end
         OP_TEST: begin
            store = 1'b0;
            fv    = 1'b1;
            zf    = (a & b) == '0;
            cf    = (b & ~a) == '0;
         end
         default: store = 1'b0;
      endcase
      res &= m;
   end

   assign wr_en = out_load && store && !dst_ext_ff && dst_ok_ff;

   // register file
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd1_ff <= mem[a1];
         rd2_ff <= mem[a2];
      end
      if (wr_en) begin
         mem[dst_ff] <= res;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[dst_ff] = 1'b1;
      end
      stg_vld_in = req_acc ? 1'b1 : (out_load ? 1'b0 : stg_vld_ff);
      rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         stg_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         stg_vld_ff   <= stg_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff      <= req_type;
         wsel_ff    <= req_width_sel;
         dst_ff     <= IDX_W'(req_dest_index);
         dst_ok_ff  <= d_in_range;
         dst_ext_ff <= req_dest_is_external;
         src_ext_ff <= req_src_is_external;
         ext_ff     <= req_external_value;
         cnt_ff     <= req_shift_count;
         s1_ok_ff   <= s1_in_range && vld_ff[a1];
         s2_ok_ff   <= s2_in_range && vld_ff[a2];
      end
      if (out_load) begin
         res_ff <= (fv) ? '0 : res;
         wr_ff  <= wr_en;
         fv_ff  <= fv;
         zf_ff  <= zf;
         cf_ff  <= cf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_reg_written  = wr_ff;
   assign rsp_flags_valid  = fv_ff;
   assign rsp_zero_flag    = zf_ff;
   assign rsp_carry_flag   = cf_ff;

   a_acc_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> stg_vld_ff)
      else $error("accepted item did not reach execute");

   a_write_when_leaving: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (stg_vld_ff && out_load))
      else $error("register write without an item leaving execute");

   a_flags_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(fv_ff && wr_ff))
      else $error("test item wrote a mask register");

   a_wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(dst_ff)])
      else $error("written register not marked valid");

endmodule
